// ----- rtl/core/bezier_curve_sampler_core_assert.svh -----
// Assertion macros for the Bezier curve sampler.
// Included by the sampler core, which checks its own sequencing.
`ifndef BEZIER_CURVE_SAMPLER_CORE_ASSERT_SVH
`define BEZIER_CURVE_SAMPLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BZS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BZS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BZS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BZS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/bzs_pkg.sv -----
// Shared types and constants for the Bezier curve sampler.
// No dependencies; used by bzs_lerp, the sampler core and the testbench.
package bzs_pkg;

    localparam int COORD_W        = 20;
    localparam int PT_W           = 2 * COORD_W;
    localparam int PIDX_W         = 4;
    localparam int STEPS_W        = 11;
    localparam int PCNT_W         = 5;
    localparam int T_FRAC         = 16;
    localparam int T_W            = T_FRAC + 1;
    localparam int DIV_W          = STEPS_W + T_FRAC;
    localparam int DEF_MAX_POINTS = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEPS = 2'd1;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd120;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_bzs_pt;

    typedef struct packed {
        logic                      command;
        logic [PIDX_W-1:0]         point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [STEPS_W-1:0]        sample_index;
    } t_bzs_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
        logic                      valid_res;
        logic                      last_sample;
    } t_bzs_res;

endpackage

// ----- rtl/core/bzs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bzs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bzs_lerp.sv -----
// Two-lane unsigned Q1.16 linear interpolation unit, round to nearest, one product register.
// Depends on bzs_pkg.
module bzs_lerp import bzs_pkg::*; #(
    parameter int AW = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  logic [AW-1:0]  i_idx,
    input  logic [T_W-1:0] i_t,
    input  t_bzs_pt        i_a,
    input  t_bzs_pt        i_b,
    output logic           o_vld,
    output logic [AW-1:0]  o_idx,
    output t_bzs_pt        o_p
);

    localparam int PROD_W = COORD_W + 1 + T_W + 1;
    localparam int Q_W    = PROD_W - T_FRAC;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1 << (T_FRAC - 1));

    logic signed [COORD_W:0]   w_dx;
    logic signed [COORD_W:0]   w_dy;
    logic signed [T_W:0]       w_tm;
    logic signed [PROD_W-1:0]  r_prod_x;
    logic signed [PROD_W-1:0]  r_prod_y;
    t_bzs_pt                   r_a;
    logic [AW-1:0]             r_idx;
    logic                      r_vld;
    logic signed [PROD_W-1:0]  w_sx;
    logic signed [PROD_W-1:0]  w_sy;
    logic signed [Q_W-1:0]     w_qx;
    logic signed [Q_W-1:0]     w_qy;
    logic signed [Q_W-1:0]     w_px;
    logic signed [Q_W-1:0]     w_py;

    assign w_dx = (COORD_W + 1)'(i_b.x) - (COORD_W + 1)'(i_a.x);
    assign w_dy = (COORD_W + 1)'(i_b.y) - (COORD_W + 1)'(i_a.y);
    assign w_tm = $signed({1'b0, i_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_prod_x <= w_dx * w_tm;
            r_prod_y <= w_dy * w_tm;
            r_a      <= i_a;
            r_idx    <= i_idx;
        end
    end

    assign w_sx = r_prod_x + RND;
    assign w_sy = r_prod_y + RND;
    assign w_qx = w_sx[PROD_W-1:T_FRAC];
    assign w_qy = w_sy[PROD_W-1:T_FRAC];
    assign w_px = w_qx + Q_W'(r_a.x);
    assign w_py = w_qy + Q_W'(r_a.y);

    assign o_vld   = r_vld;
    assign o_idx   = r_idx;
    assign o_p.x   = w_px[COORD_W-1:0];
    assign o_p.y   = w_py[COORD_W-1:0];

endmodule

// ----- rtl/core/bezier_curve_sampler_core.sv -----
// Bezier curve sampler: control point store and de Casteljau evaluator.
// Write request: taken while idle, no result, busy stays low.
// Evaluate request, n points in use: a 27-step t divider, then one interpolation a cycle
// per round, with a turnaround after each round; one point or none skip the divider.
// Next request is taken in the strobe cycle. Sync reset, low. Needs bzs_pkg, bzs_ram, bzs_lerp.
`include "bezier_curve_sampler_core_assert.svh"

module bezier_curve_sampler_core import bzs_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_bzs_req              i_req,
    output logic                  busy,
    output logic                  o_strobe,
    output t_bzs_res              o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int NW  = (CW > PCNT_W) ? CW : PCNT_W;
    localparam int IW  = ((AW > PIDX_W) ? AW : PIDX_W) + 1;
    localparam int DCW = $clog2(DIV_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_ONE   = 5'b00100,
        S_READ  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [PCNT_W-1:0]    r_point_count;
    logic [STEPS_W-1:0]   r_sample_steps;
    logic [STEPS_W-1:0]   r_den;
    logic                 r_last;
    logic [DIV_W-1:0]     r_div_n;
    logic [STEPS_W-1:0]   r_rem;
    logic [DCW-1:0]       r_div_cnt;
    logic [AW-1:0]        r_m;
    logic [AW-1:0]        r_k;
    logic                 r_src_cp;
    logic                 r_drain;
    logic                 r_d1_vld;
    logic                 r_d1_first;
    logic                 r_d1_src;
    logic [AW-1:0]        r_d1_k;
    t_bzs_pt              r_prev;
    logic                 r_out_vld;
    t_bzs_res             r_out;

    logic                 w_acc;
    logic                 w_acc_eval;
    logic [STEPS_W-1:0]   w_steps;
    logic [STEPS_W-1:0]   w_i;
    logic                 w_last;
    logic [NW-1:0]        w_pc;
    logic [NW-1:0]        w_n;
    logic [IW-1:0]        w_widx;
    logic                 w_cp_we;
    logic [AW-1:0]        w_raddr;
    logic [PT_W-1:0]      w_cp_q;
    logic [PT_W-1:0]      w_wk_q;
    t_bzs_pt              w_cp_pt;
    t_bzs_pt              w_wk_pt;
    t_bzs_pt              w_q;
    t_bzs_pt              w_wdata;
    logic [STEPS_W:0]     w_rem_sh;
    logic [STEPS_W:0]     w_rem_sub;
    logic                 w_ge;
    logic                 w_lp_vld;
    logic [AW-1:0]        w_lp_idx;
    t_bzs_pt              w_lp_p;
    logic                 w_final;

    assign w_acc      = start && !busy;
    assign w_acc_eval = w_acc && (i_req.command == CMD_EVAL);
    assign w_steps    = (r_sample_steps == '0) ? STEPS_W'(1) : r_sample_steps;
    assign w_i        = (i_req.sample_index > w_steps) ? w_steps : i_req.sample_index;
    assign w_last     = (w_i == w_steps);
    assign w_pc       = NW'(r_point_count);
    assign w_n        = (w_pc > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : w_pc;

    assign w_widx     = IW'(i_req.point_index);
    assign w_cp_we    = w_acc && (i_req.command == CMD_WRITE) && (w_widx < IW'(MAX_POINTS));
    assign w_wdata.x  = i_req.point_x;
    assign w_wdata.y  = i_req.point_y;
    assign w_raddr    = (r_state == S_READ) ? r_k : '0;

    bzs_ram #(.W(PT_W), .D(MAX_POINTS)) u_cp_ram (
        .i_clk   (i_clk),
        .i_we    (w_cp_we),
        .i_waddr (AW'(w_widx)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_cp_q)
    );

    bzs_ram #(.W(PT_W), .D(MAX_POINTS)) u_wk_ram (
        .i_clk   (i_clk),
        .i_we    (w_lp_vld),
        .i_waddr (w_lp_idx),
        .i_wdata (w_lp_p),
        .i_raddr (w_raddr),
        .o_rdata (w_wk_q)
    );

    assign w_cp_pt = t_bzs_pt'(w_cp_q);
    assign w_wk_pt = t_bzs_pt'(w_wk_q);
    assign w_q     = r_d1_src ? w_cp_pt : w_wk_pt;

    bzs_lerp #(.AW(AW)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_d1_vld && !r_d1_first),
        .i_idx   (r_d1_k - AW'(1)),
        .i_t     (r_div_n[T_W-1:0]),
        .i_a     (r_prev),
        .i_b     (w_q),
        .o_vld   (w_lp_vld),
        .o_idx   (w_lp_idx),
        .o_p     (w_lp_p)
    );

    assign w_final   = w_lp_vld && (r_m == AW'(1));

    assign w_rem_sh  = {r_rem, r_div_n[DIV_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc_eval) begin
                    if (w_n == '0) begin
                        n_state = S_IDLE;
                    end else if (w_n == NW'(1)) begin
                        n_state = S_ONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = S_READ;
                end
            end
            S_ONE: begin
                n_state = S_IDLE;
            end
            S_READ: begin
                if (r_k == r_m) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = (r_m == AW'(1)) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_point_count  <= '0;
            r_sample_steps <= STEPS_RESET;
            r_div_cnt      <= '0;
            r_m            <= '0;
            r_k            <= '0;
            r_src_cp       <= 1'b0;
            r_drain        <= 1'b0;
            r_d1_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_d1_vld  <= (r_state == S_READ);
            r_out_vld <= (w_acc_eval && (r_state == S_IDLE) && (w_n == '0))
                         || (r_state == S_ONE) || w_final;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POINT_COUNT:  r_point_count  <= i_cfg_data[PCNT_W-1:0];
                    CFG_SAMPLE_STEPS: r_sample_steps <= i_cfg_data[STEPS_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_eval) begin
                        r_div_cnt <= DCW'(DIV_W - 1);
                        r_m       <= AW'(w_n - NW'(1));
                        r_k       <= '0;
                        r_src_cp  <= 1'b1;
                    end
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt - DCW'(1);
                end
                S_ONE: ;
                S_READ: begin
                    r_k     <= r_k + AW'(1);
                    r_drain <= 1'b0;
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain && (r_m != AW'(1))) begin
                        r_m      <= r_m - AW'(1);
                        r_k      <= '0;
                        r_src_cp <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_first <= (r_k == '0);
        r_d1_src   <= r_src_cp;
        r_d1_k     <= r_k;
        if (r_d1_vld) begin
            r_prev <= w_q;
        end
        if ((r_state == S_IDLE) && w_acc_eval) begin
            r_last            <= w_last;
            r_den             <= w_steps;
            r_rem             <= '0;
            r_div_n           <= {w_i, T_FRAC'(0)} + DIV_W'(w_steps >> 1);
            r_out.curve_x     <= '0;
            r_out.curve_y     <= '0;
            r_out.valid_res   <= 1'b0;
            r_out.last_sample <= w_last;
        end
        if (r_state == S_DIV) begin
            r_rem   <= w_ge ? w_rem_sub[STEPS_W-1:0] : w_rem_sh[STEPS_W-1:0];
            r_div_n <= {r_div_n[DIV_W-2:0], w_ge};
        end
        if (r_state == S_ONE) begin
            r_out.curve_x     <= w_cp_pt.x;
            r_out.curve_y     <= w_cp_pt.y;
            r_out.valid_res   <= 1'b0;
            r_out.last_sample <= r_last;
        end
        if (w_final) begin
            r_out.curve_x     <= w_lp_p.x;
            r_out.curve_y     <= w_lp_p.y;
            r_out.valid_res   <= 1'b1;
            r_out.last_sample <= r_last;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_out_vld;
    assign o_res       = r_out;
    assign o_cfg_ready = 1'b1;

    `BZS_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result while busy")
    `BZS_ASSERT_NXT(a_eval_progress, i_clk, i_rst_n, w_acc_eval, busy || o_strobe,
                    "evaluate request dropped")
    `BZS_ASSERT_IMP(a_lerp_in_round, i_clk, i_rst_n, w_lp_vld,
                    (r_state == S_READ) || (r_state == S_DRAIN), "interpolation outside a round")
    `BZS_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_den,
                    "divider remainder out of range")

endmodule

// ----- tb/tb_bezier_curve_sampler_core.sv -----
// Self-checking testbench for bezier_curve_sampler_core: control point writes and
// curve sample requests are checked against a de Casteljau predictor kept here.
// Depends on bzs_pkg and the block's RTL only.
module tb_bezier_curve_sampler_core;
    import bzs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = DEF_MAX_POINTS;
    localparam int LIMIT   = 2_000_000;
    localparam int PHASES  = 30;
    localparam int PHASE_ITEMS = 62;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    t_bzs_req              i_req       = '0;
    logic                  busy;
    logic                  o_strobe;
    t_bzs_res              o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_bzs_req pending[$];
    t_bzs_res expected_samples[$];

    t_bzs_pt               curve_pts [MAX_PTS];
    logic [PCNT_W-1:0]     cur_points = '0;
    logic [STEPS_W-1:0]    cur_steps  = STEPS_RESET;

    int       issued = 0;
    int       taken = 0;
    int       gap_left = 0;
    bit       no_gaps = 1'b0;
    logic     start_next;
    t_bzs_res want;

    int n_fail = 0;
    int n_writes = 0;
    int n_evals = 0;
    int n_checked = 0;
    int n_last = 0;
    int n_valid = 0;
    int n_cfg = 0;
    int cycle_cnt = 0;

    bezier_curve_sampler_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] blend(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input longint t
    );
        longint s;
        s = longint'(a) * (65536 - t) + longint'(b) * t + 32768;
        return COORD_W'(s >>> T_FRAC);
    endfunction

    function automatic t_bzs_res sample_curve(input t_bzs_req rq);
        longint steps;
        longint idx;
        longint t;
        int n;
        int j;
        int k;
        logic signed [COORD_W-1:0] wx [MAX_PTS];
        logic signed [COORD_W-1:0] wy [MAX_PTS];
        t_bzs_res r;
        steps = (cur_steps == '0) ? longint'(1) : longint'(cur_steps);
        idx = longint'(rq.sample_index);
        if (idx > steps) idx = steps;
        t = (idx * 65536 + steps / 2) / steps;
        n = (int'(cur_points) > MAX_PTS) ? MAX_PTS : int'(cur_points);
        r = '0;
        for (k = 0; k < n; k++) begin
            wx[k] = curve_pts[k].x;
            wy[k] = curve_pts[k].y;
        end
        for (j = 1; j < n; j++) begin
            for (k = 0; k + j < n; k++) begin
                wx[k] = blend(wx[k], wx[k+1], t);
                wy[k] = blend(wy[k], wy[k+1], t);
            end
        end
        if (n >= 2) begin
            r.curve_x   = wx[0];
            r.curve_y   = wy[0];
            r.valid_res = 1'b1;
        end else if (n == 1) begin
            r.curve_x = curve_pts[0].x;
            r.curve_y = curve_pts[0].y;
        end
        r.last_sample = (idx == steps);
        return r;
    endfunction

    // driver: hold the request until taken, then idle for the drawn gap
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            start_next = start;
            if (start && taken == issued) start_next = 1'b0;
            if (!start_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    i_req <= pending.pop_front();
                    start_next = 1'b1;
                    issued++;
                    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
                    gap_left = no_gaps ? 0 : int'($urandom_range(0, 10));
                end
            end
            start <= start_next;
        end
    end

    // monitor: check results first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_samples.size() == 0) begin
                    $error("curve result with no sample request outstanding");
                    n_fail++;
                end else begin
                    want = expected_samples.pop_front();
                    n_checked++;
                    if (want.last_sample) n_last++;
                    if (want.valid_res) n_valid++;
                    if (o_res.curve_x !== want.curve_x) begin
                        $error("curve_x expected %0d got %0d", want.curve_x, o_res.curve_x);
                        n_fail++;
                    end
                    if (o_res.curve_y !== want.curve_y) begin
                        $error("curve_y expected %0d got %0d", want.curve_y, o_res.curve_y);
                        n_fail++;
                    end
                    if (o_res.valid_res !== want.valid_res) begin
                        $error("valid_res expected %0d got %0d",
                               want.valid_res, o_res.valid_res);
                        n_fail++;
                    end
                    if (o_res.last_sample !== want.last_sample) begin
                        $error("last_sample expected %0d got %0d",
                               want.last_sample, o_res.last_sample);
                        n_fail++;
                    end
                end
            end
            if (start && !busy) begin
                taken <= taken + 1;
                if (i_req.command == CMD_WRITE) begin
                    if (i_req.point_index < MAX_PTS) begin
                        curve_pts[i_req.point_index].x = i_req.point_x;
                        curve_pts[i_req.point_index].y = i_req.point_y;
                    end
                    n_writes++;
                end else begin
                    expected_samples = {expected_samples, sample_curve(i_req)};
                    n_evals++;
                end
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return COORD_W'($urandom_range(0, 63) - 32);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [STEPS_W-1:0] pick_sample();
        int lim;
        lim = (cur_steps == '0) ? 1 : int'(cur_steps);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return STEPS_W'(lim);
            2: return STEPS_W'($urandom);
            default: return STEPS_W'($urandom_range(0, lim));
        endcase
    endfunction

    function automatic logic [PCNT_W-1:0] pick_points();
        case ($urandom_range(0, 9))
            0: return PCNT_W'($urandom_range(0, 1));
            1, 2, 3, 4, 5: return PCNT_W'($urandom_range(2, 6));
            6: return PCNT_W'($urandom_range(7, 15));
            7, 8: return PCNT_W'(MAX_PTS);
            default: return PCNT_W'($urandom_range(17, 31));
        endcase
    endfunction

    function automatic logic [STEPS_W-1:0] pick_steps();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return STEPS_W'(1);
            2: return {STEPS_W{1'b1}};
            3: return STEPS_W'(1024);
            4: return STEPS_W'($urandom_range(1, 16));
            default: return STEPS_W'($urandom_range(1, 2047));
        endcase
    endfunction

    task automatic add_write(input logic [PIDX_W-1:0] slot,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        t_bzs_req rq;
        rq.command      = CMD_WRITE;
        rq.point_index  = slot;
        rq.point_x      = x;
        rq.point_y      = y;
        rq.sample_index = STEPS_W'($urandom);
        pending = {pending, rq};
    endtask

    task automatic add_eval(input logic [STEPS_W-1:0] si);
        t_bzs_req rq;
        rq.command      = CMD_EVAL;
        rq.point_index  = PIDX_W'($urandom);
        rq.point_x      = rand_coord();
        rq.point_y      = rand_coord();
        rq.sample_index = si;
        pending = {pending, rq};
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || taken != issued || expected_samples.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_POINT_COUNT:  cur_points = data[PCNT_W-1:0];
            CFG_SAMPLE_STEPS: cur_steps  = data[STEPS_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_points(input logic [PCNT_W-1:0] pc);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        d[PCNT_W-1:0] = pc;
        set_reg(CFG_POINT_COUNT, d);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store at reset settings, extremes, steps of zero, clamping
        add_eval('0);
        add_eval({STEPS_W{1'b1}});
        add_write(PIDX_W'(0), COORD_MAX, COORD_MIN);
        add_write(PIDX_W'(1), COORD_MIN, COORD_MAX);
        add_write(PIDX_W'(2), COORD_MAX, COORD_MAX);
        add_write(PIDX_W'(3), COORD_MIN, COORD_MIN);
        wait_idle();
        set_points(PCNT_W'(1));
        set_reg(CFG_SAMPLE_STEPS, '0);
        add_eval('0);
        add_eval(STEPS_W'(1));
        add_eval({STEPS_W{1'b1}});
        wait_idle();
        set_points(PCNT_W'(2));
        set_reg(CFG_SAMPLE_STEPS, CFG_DATA_W'(1024));
        add_eval('0);
        add_eval(STEPS_W'(1));
        add_eval(STEPS_W'(512));
        add_eval(STEPS_W'(1023));
        add_eval(STEPS_W'(1024));
        wait_idle();
        set_points(PCNT_W'(4));
        set_reg(CFG_SAMPLE_STEPS, CFG_DATA_W'(3));
        add_eval(STEPS_W'(1));
        add_eval(STEPS_W'(2));
        add_write(PIDX_W'(2), rand_coord(), rand_coord());
        add_eval(STEPS_W'(3));
        wait_idle();
        set_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
        set_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
        add_eval(STEPS_W'(2));

        // random: fill the whole store, then sweep register settings
        for (int k = 0; k < MAX_PTS; k++) add_write(PIDX_W'(k), rand_coord(), rand_coord());
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    set_points(PCNT_W'(MAX_PTS));
                    set_reg(CFG_SAMPLE_STEPS, {STEPS_W{1'b1}});
                end
                1: begin
                    set_points(PCNT_W'(31));
                    set_reg(CFG_SAMPLE_STEPS, CFG_DATA_W'(1));
                end
                2: begin
                    set_points('0);
                    set_reg(CFG_SAMPLE_STEPS, CFG_DATA_W'(2));
                end
                default: begin
                    if ($urandom_range(0, 3) != 0) set_reg(CFG_SAMPLE_STEPS, pick_steps());
                    if ($urandom_range(0, 3) != 0) set_points(pick_points());
                    if ($urandom_range(0, 7) == 0) set_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
                end
            endcase
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    add_write(PIDX_W'($urandom), rand_coord(), rand_coord());
                else
                    add_eval(pick_sample());
            end
        end

        wait_idle();
        repeat (200) @(negedge i_clk);
        $display("Sent %0d point writes and %0d curve samples across %0d register writes;",
                 n_writes, n_evals, n_cfg);
        $display("checked %0d results, %0d with a valid curve and %0d marked last.",
                 n_checked, n_valid, n_last);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
